### hw/rtl/fracc_pkg.sv
// ----------------------------------------------------------------------------
// fracc_pkg: shared types and constants of the fraction accumulator
// Widths, operation and error codes, controller states, and the command and
// status words that join the controller to the datapath.
// ----------------------------------------------------------------------------
package fracc_pkg;

	localparam int ACC_WIDTH     = 32;
	localparam int OPERAND_WIDTH = 16;

	// magnitude width of the accumulator (sign kept apart)
	localparam int MAG_W  = ACC_WIDTH - 1;
	localparam int OPD_W  = OPERAND_WIDTH - 1;
	localparam int PROD_W = MAG_W + OPERAND_WIDTH;
	localparam int RES_NUM_W = 32;
	localparam int RES_DEN_W = 31;

	localparam logic [MAG_W-1:0] MAG_LIMIT = {MAG_W{1'b1}};

	typedef enum logic [1:0] {
		OP_MUL = 2'd0,
		OP_ADD = 2'd1,
		OP_SUB = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_DIVZERO  = 2'd1,
		ERR_OVERFLOW = 2'd2
	} err_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_MUL1,
		S_MUL2,
		S_MUL3,
		S_COMMIT,
		S_CHECK_LAST,
		S_GCD_TEST,
		S_GCD_WAIT,
		S_NUM_WAIT,
		S_DEN_WAIT,
		S_EMIT,
		S_EMIT_ERR
	} ctrl_state_t;

	typedef enum logic [3:0] {
		CMD_NOP,
		CMD_CAPTURE,
		CMD_LOAD_FIRST,
		CMD_MUL1,
		CMD_MUL2,
		CMD_MUL3,
		CMD_COMMIT,
		CMD_GCD_INIT,
		CMD_GCD_START,
		CMD_GCD_STEP,
		CMD_NUM_START,
		CMD_DEN_START,
		CMD_FINISH,
		CMD_EMIT_ERR
	} dp_cmd_t;

	typedef struct packed {
		logic first;
		logic last;
		logic err;
		logic divz;
		logic addsub;
		logic gb_zero;
		logic div_done;
		logic out_full;
	} dp_status_t;

endpackage

### hw/rtl/fraction_accumulator_reduce.sv
// ----------------------------------------------------------------------------
// fraction_accumulator_reduce: rational accumulator with gcd reduction
// Combines fraction operands into an accumulated fraction and emits the
// reduced fraction on a word marked last.
// ----------------------------------------------------------------------------
//
//  channel | handshake                 | payload
//  --------+---------------------------+-----------------------------------
//  item    | item_valid / item_ready   | operation numerator denominator
//          |                           | first last
//  result  | result_valid/result_ready | result_numerator result_denominator
//          |                           | error_code
//
// A first word is loaded as it stands; multiply or divide forms the MUL1 and
// MUL2 products, add or subtract also MUL3, all paced by the single shared
// multiplier, one product per cycle. A last word adds the gcd loop on the
// bit-serial divider: the Euclid steps, then the final test, the two reducing
// divisions and the write-back.
// Reset clears the accumulator to 0/1 and the sticky error at once.
// The result register holds one word; a new result waits until it is taken,
// while the next item word is accepted as soon as the previous one is done.
//
module fraction_accumulator_reduce import fracc_pkg::*; (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  logic [1:0]                      operation,
	input  logic signed [OPERAND_WIDTH-1:0] numerator,
	input  logic [OPD_W-1:0]                denominator,
	input  logic                            first,
	input  logic                            last,
	output logic                            result_valid,
	input  logic                            result_ready,
	output logic signed [RES_NUM_W-1:0]     result_numerator,
	output logic [RES_DEN_W-1:0]            result_denominator,
	output logic [1:0]                      error_code
);

	dp_cmd_t    cmd;
	dp_status_t status;

	fracc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.status     (status),
		.cmd        (cmd)
	);

	fracc_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.status             (status),
		.operation          (operation),
		.numerator          (numerator),
		.denominator        (denominator),
		.first              (first),
		.last               (last),
		.result_valid       (result_valid),
		.result_ready       (result_ready),
		.result_numerator   (result_numerator),
		.result_denominator (result_denominator),
		.error_code         (error_code)
	);

endmodule

### hw/rtl/fracc_div.sv
// ----------------------------------------------------------------------------
// fracc_div: restoring divider
// Unsigned quotient and remainder, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fracc_div import fracc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [MAG_W-1:0] dividend,
	input  logic [MAG_W-1:0] divisor,
	output logic             busy,
	output logic             done,
	output logic [MAG_W-1:0] quotient,
	output logic [MAG_W-1:0] remainder
);

	localparam int CNT_W = $clog2(MAG_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MAG_W-1:0] dvd_q;
	logic [MAG_W-1:0] dvs_q;
	logic [MAG_W-1:0] rem_q;

	logic [MAG_W:0] trial;
	logic [MAG_W:0] diff;
	logic           ge;

	// trial subtract of the shifted partial remainder
	always_comb begin
		trial = {rem_q, dvd_q[MAG_W-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = trial >= {1'b0, dvs_q};
	end

	// control: busy while shifting, done held until the next start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(MAG_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// shift the quotient in, keep the partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[MAG_W-2:0], ge};
			rem_q <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;

endmodule

### hw/rtl/fracc_dp.sv
// ----------------------------------------------------------------------------
// fracc_dp: fraction accumulator datapath
// Operand capture, shared multiplier, sign-magnitude combine, gcd registers
// with the shared divider, accumulator and the output word register.
// ----------------------------------------------------------------------------
module fracc_dp import fracc_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dp_cmd_t                     cmd,
	output dp_status_t                  status,
	input  logic [1:0]                  operation,
	input  logic signed [OPERAND_WIDTH-1:0] numerator,
	input  logic [OPD_W-1:0]            denominator,
	input  logic                        first,
	input  logic                        last,
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic signed [RES_NUM_W-1:0] result_numerator,
	output logic [RES_DEN_W-1:0]        result_denominator,
	output logic [1:0]                  error_code
);

	// operand word
	op_t                      op_q;
	logic [OPERAND_WIDTH-1:0] on_q;
	logic                     on_neg_q;
	logic [OPD_W-1:0]         od_q;
	logic                     first_q;
	logic                     last_q;

	// accumulator, sign-magnitude
	logic [MAG_W-1:0] acc_mag_q;
	logic             acc_neg_q;
	logic [MAG_W-1:0] acc_den_q;
	err_t             err_q;

	// products and gcd work registers
	logic [MAG_W-1:0] t1_q, t2_q, t3_q;
	logic             ovf_q;
	logic [MAG_W-1:0] ga_q, gb_q, qn_q;

	logic                        out_valid_q;
	logic signed [RES_NUM_W-1:0] out_num_q;
	logic [RES_DEN_W-1:0]        out_den_q;
	err_t                        out_err_q;

	logic                     cap_neg;
	logic [OPERAND_WIDTH-1:0] cap_mag;
	logic [OPERAND_WIDTH-1:0] od_ext;
	logic [MAG_W-1:0]         mul_a;
	logic [OPERAND_WIDTH-1:0] mul_b;
	logic [PROD_W-1:0]        prod;
	logic                     prod_ovf;
	logic                     divz;
	logic                     addsub;
	logic                     sa, sb, sum_s;
	logic [MAG_W:0]           sum_m;
	logic                     sum_neg;
	logic                     sum_ovf;
	logic                     first_ovf;

	logic             div_start;
	logic [MAG_W-1:0] div_dvd;
	logic [MAG_W-1:0] div_dvs;
	logic             div_busy;
	logic             div_done;
	logic [MAG_W-1:0] div_quo;
	logic [MAG_W-1:0] div_rem;

	logic [MAG_W-1:0]            fin_mag;
	logic                        fin_neg;
	logic signed [ACC_WIDTH-1:0] fin_num;

	// split the incoming numerator into sign and magnitude
	always_comb begin
		cap_neg = numerator[OPERAND_WIDTH-1];
		cap_mag = cap_neg ? (~numerator + 1'b1) : numerator;
	end

	// pick multiplier operands by step
	always_comb begin
		od_ext = OPERAND_WIDTH'(od_q);
		mul_a  = acc_den_q;
		mul_b  = od_ext;
		case (cmd)
			CMD_MUL1: begin
				mul_a = acc_mag_q;
				mul_b = (op_q == OP_MUL) ? on_q : od_ext;
			end
			CMD_MUL2: begin
				mul_a = acc_den_q;
				mul_b = (op_q == OP_MUL) ? od_ext : on_q;
			end
			default: begin
				mul_a = acc_den_q;
				mul_b = od_ext;
			end
		endcase
		prod     = PROD_W'(mul_a) * PROD_W'(mul_b);
		prod_ovf = |prod[PROD_W-1:MAG_W];
	end

	// signed add of the cross products
	always_comb begin
		divz   = (od_q == '0) || ((op_q == OP_DIV) && (on_q == '0));
		addsub = (op_q == OP_ADD) || (op_q == OP_SUB);
		sa     = acc_neg_q;
		sb     = on_neg_q ^ (op_q == OP_SUB);
		if (sa == sb) begin
			sum_m = {1'b0, t1_q} + {1'b0, t2_q};
			sum_s = sa;
		end else if (t1_q >= t2_q) begin
			sum_m = {1'b0, t1_q} - {1'b0, t2_q};
			sum_s = sa;
		end else begin
			sum_m = {1'b0, t2_q} - {1'b0, t1_q};
			sum_s = sb;
		end
		sum_ovf   = sum_m[MAG_W];
		sum_neg   = sum_s && (sum_m != '0);
		first_ovf = (PROD_W'(on_q) > PROD_W'(MAG_LIMIT))
			|| (PROD_W'(od_q) > PROD_W'(MAG_LIMIT));
	end

	// route the divider by command
	always_comb begin
		div_start = 1'b0;
		div_dvd   = ga_q;
		div_dvs   = gb_q;
		case (cmd)
			CMD_GCD_START: begin
				div_start = 1'b1;
			end
			CMD_NUM_START: begin
				div_start = 1'b1;
				div_dvd   = acc_mag_q;
				div_dvs   = ga_q;
			end
			CMD_DEN_START: begin
				div_start = 1'b1;
				div_dvd   = acc_den_q;
				div_dvs   = ga_q;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	fracc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dvd),
		.divisor   (div_dvs),
		.busy      (div_busy),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// reduced fraction for write-back and output
	always_comb begin
		fin_mag = qn_q;
		fin_neg = acc_neg_q && (qn_q != '0);
		fin_num = fin_neg ? -signed'({1'b0, fin_mag}) : signed'({1'b0, fin_mag});
	end

	// hold the operand word
	always_ff @(posedge clk) begin
		if (cmd == CMD_CAPTURE) begin
			op_q     <= op_t'(operation);
			on_q     <= cap_mag;
			on_neg_q <= cap_neg;
			od_q     <= denominator;
			first_q  <= first;
			last_q   <= last;
		end
	end

	// products and gcd work registers
	always_ff @(posedge clk) begin
		case (cmd)
			CMD_MUL1: t1_q <= prod[MAG_W-1:0];
			CMD_MUL2: t2_q <= prod[MAG_W-1:0];
			CMD_MUL3: t3_q <= prod[MAG_W-1:0];
			CMD_GCD_INIT: begin
				ga_q <= acc_den_q;
				gb_q <= acc_mag_q;
			end
			CMD_GCD_STEP: begin
				ga_q <= gb_q;
				gb_q <= div_rem;
			end
			CMD_DEN_START: qn_q <= div_quo;
			default: ;
		endcase
	end

	// overflow of any product of the item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_q <= 1'b0;
		end else if (cmd == CMD_CAPTURE) begin
			ovf_q <= 1'b0;
		end else if (cmd == CMD_MUL1 || cmd == CMD_MUL2 || cmd == CMD_MUL3) begin
			ovf_q <= ovf_q | prod_ovf;
		end
	end

	// accumulator and sticky error
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_mag_q <= '0;
			acc_neg_q <= 1'b0;
			acc_den_q <= MAG_W'(1);
			err_q     <= ERR_NONE;
		end else begin
			case (cmd)
				CMD_LOAD_FIRST: begin
					if (od_q == '0) begin
						err_q <= ERR_DIVZERO;
					end else if (first_ovf) begin
						err_q <= ERR_OVERFLOW;
					end else begin
						err_q     <= ERR_NONE;
						acc_mag_q <= MAG_W'(on_q);
						acc_neg_q <= on_neg_q && (on_q != '0);
						acc_den_q <= MAG_W'(od_q);
					end
				end
				CMD_COMMIT: begin
					if (divz) begin
						err_q <= ERR_DIVZERO;
					end else if (ovf_q) begin
						err_q <= ERR_OVERFLOW;
					end else if (addsub) begin
						if (sum_ovf) begin
							err_q <= ERR_OVERFLOW;
						end else begin
							acc_mag_q <= sum_m[MAG_W-1:0];
							acc_neg_q <= sum_neg;
							acc_den_q <= t3_q;
						end
					end else begin
						acc_mag_q <= t1_q;
						acc_neg_q <= (acc_neg_q != on_neg_q) && (t1_q != '0);
						acc_den_q <= t2_q;
					end
				end
				CMD_FINISH: begin
					acc_mag_q <= fin_mag;
					acc_neg_q <= fin_neg;
					acc_den_q <= div_quo;
				end
				default: ;
			endcase
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd == CMD_FINISH || cmd == CMD_EMIT_ERR) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output word data
	always_ff @(posedge clk) begin
		if (cmd == CMD_FINISH) begin
			out_num_q <= RES_NUM_W'(fin_num);
			out_den_q <= RES_DEN_W'(div_quo);
			out_err_q <= ERR_NONE;
		end else if (cmd == CMD_EMIT_ERR) begin
			out_num_q <= '0;
			out_den_q <= RES_DEN_W'(1);
			out_err_q <= err_q;
		end
	end

	assign result_valid       = out_valid_q;
	assign result_numerator   = out_num_q;
	assign result_denominator = out_den_q;
	assign error_code         = out_err_q;

	always_comb begin
		status.first    = first_q;
		status.last     = last_q;
		status.err      = (err_q != ERR_NONE);
		status.divz     = divz;
		status.addsub   = addsub;
		status.gb_zero  = (gb_q == '0);
		status.div_done = div_done;
		status.out_full = out_valid_q;
	end

`ifndef SYNTHESIS
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		acc_den_q != '0)
		else $error("accumulated denominator is zero");

	a_neg_has_mag: assert property (@(posedge clk) disable iff (!arst_n)
		acc_neg_q |-> (acc_mag_q != '0))
		else $error("negative sign on a zero numerator");

	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	a_emit_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_FINISH || cmd == CMD_EMIT_ERR) |-> !out_valid_q)
		else $error("result word overwritten before taken");
`endif

endmodule

### hw/rtl/fracc_ctrl.sv
// ----------------------------------------------------------------------------
// fracc_ctrl: fraction accumulator controller
// Sequences capture, multiplies, commit, gcd loop, the two reducing
// divisions and the emit of the result word.
// ----------------------------------------------------------------------------
module fracc_ctrl import fracc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	// advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				if (status.first || status.err) state_d = S_CHECK_LAST;
				else if (status.divz)           state_d = S_COMMIT;
				else                            state_d = S_MUL1;
			end
			S_MUL1: state_d = S_MUL2;
			S_MUL2: state_d = status.addsub ? S_MUL3 : S_COMMIT;
			S_MUL3: state_d = S_COMMIT;
			S_COMMIT: state_d = S_CHECK_LAST;
			S_CHECK_LAST: begin
				if (!status.last)    state_d = S_IDLE;
				else if (status.err) state_d = S_EMIT_ERR;
				else                 state_d = S_GCD_TEST;
			end
			S_GCD_TEST: state_d = status.gb_zero ? S_NUM_WAIT : S_GCD_WAIT;
			S_GCD_WAIT: begin
				if (status.div_done) state_d = S_GCD_TEST;
			end
			S_NUM_WAIT: begin
				if (status.div_done) state_d = S_DEN_WAIT;
			end
			S_DEN_WAIT: begin
				if (status.div_done) state_d = S_EMIT;
			end
			S_EMIT: begin
				if (!status.out_full) state_d = S_IDLE;
			end
			S_EMIT_ERR: begin
				if (!status.out_full) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd        = CMD_NOP;
		item_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) cmd = CMD_CAPTURE;
			end
			S_DISPATCH: begin
				if (status.first) cmd = CMD_LOAD_FIRST;
			end
			S_MUL1:   cmd = CMD_MUL1;
			S_MUL2:   cmd = CMD_MUL2;
			S_MUL3:   cmd = CMD_MUL3;
			S_COMMIT: cmd = CMD_COMMIT;
			S_CHECK_LAST: begin
				if (status.last && !status.err) cmd = CMD_GCD_INIT;
			end
			S_GCD_TEST: cmd = status.gb_zero ? CMD_NUM_START : CMD_GCD_START;
			S_GCD_WAIT: begin
				if (status.div_done) cmd = CMD_GCD_STEP;
			end
			S_NUM_WAIT: begin
				if (status.div_done) cmd = CMD_DEN_START;
			end
			S_DEN_WAIT: cmd = CMD_NOP;
			S_EMIT: begin
				if (!status.out_full) cmd = CMD_FINISH;
			end
			S_EMIT_ERR: begin
				if (!status.out_full) cmd = CMD_EMIT_ERR;
			end
			default: cmd = CMD_NOP;
		endcase
	end

`ifndef SYNTHESIS
	a_capture_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_CAPTURE) |=> (state_q == S_DISPATCH))
		else $error("capture did not lead to dispatch");

	a_finish_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_FINISH) |-> status.div_done)
		else $error("finish before the denominator division completed");

	a_ready_no_work: assert property (@(posedge clk) disable iff (!arst_n)
		item_ready |-> (cmd == CMD_NOP || cmd == CMD_CAPTURE))
		else $error("ready raised while a command is in progress");
`endif

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for fraction_accumulator_reduce
// Drives fraction words in runs (load, combine, reduce), holds its own
// rational accumulator to work out each reduced fraction and error code,
// and compares every result word against it with random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;
	import fracc_pkg::*;

	localparam longint unsigned MAG_MAX = 64'h7FFF_FFFF;
	localparam int CYCLE_LIMIT = 4000000;
	localparam int RANDOM_WORDS = 400;
	localparam int DRAIN_CYCLES = 2000;

	typedef struct packed {
		logic signed [RES_NUM_W-1:0] num;
		logic [RES_DEN_W-1:0] den;
		logic [1:0] err;
	} frac_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	logic [1:0] operation = OP_MUL;
	logic signed [OPERAND_WIDTH-1:0] numerator = '0;
	logic [OPD_W-1:0] denominator = '0;
	logic first = 1'b0;
	logic last = 1'b0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic signed [RES_NUM_W-1:0] result_numerator;
	logic [RES_DEN_W-1:0] result_denominator;
	logic [1:0] error_code;

	// running fraction of the predictor
	longint signed frac_num = 0;
	longint unsigned frac_den = 1;
	err_t frac_err = ERR_NONE;

	frac_result_t reduced_q[$];

	bit no_idle = 1'b0;
	int words_sent = 0;
	int live_words = 0;
	int results_seen = 0;
	int error_results = 0;
	int mismatches = 0;
	int cycles = 0;

	fraction_accumulator_reduce DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.operation(operation),
		.numerator(numerator),
		.denominator(denominator),
		.first(first),
		.last(last),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result_numerator(result_numerator),
		.result_denominator(result_denominator),
		.error_code(error_code)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Store a sign-magnitude fraction into the running accumulator
	task automatic store_frac(input bit neg, input longint unsigned mag,
			input longint unsigned den);
		frac_num = neg ? -longint'(mag) : longint'(mag);
		frac_den = den;
	endtask

	// Fold one accepted word into the running fraction; on last, reduce it
	task automatic fold_word(input op_t op, input logic signed [OPERAND_WIDTH-1:0] num,
			input logic [OPD_W-1:0] den, input bit fst, input bit lst,
			output bit emits, output frac_result_t res);
		longint signed sn;
		longint unsigned on, od, an, ad, rn, rd, p, q, a, b, t;
		bit on_neg, an_neg, rneg, ovf, sb;
		sn = num;
		on_neg = sn < 0;
		on = on_neg ? longint'(-sn) : longint'(sn);
		od = den;
		ovf = 1'b0;
		rneg = 1'b0;
		rn = 0;
		rd = 1;
		if (fst) begin
			frac_err = ERR_NONE;
			if (od == 0)
				frac_err = ERR_DIVZERO;
			else
				store_frac(on_neg && on != 0, on, od);
		end else if (frac_err == ERR_NONE) begin
			an_neg = frac_num < 0;
			an = an_neg ? longint'(-frac_num) : longint'(frac_num);
			ad = frac_den;
			if (od == 0 || (op == OP_DIV && on == 0)) begin
				frac_err = ERR_DIVZERO;
			end else begin
				case (op)
					OP_MUL: begin
						rn = an * on;
						rd = ad * od;
						ovf = rn > MAG_MAX || rd > MAG_MAX;
						rneg = (an_neg != on_neg) && rn != 0;
					end
					OP_DIV: begin
						rn = an * od;
						rd = ad * on;
						ovf = rn > MAG_MAX || rd > MAG_MAX;
						rneg = (an_neg != on_neg) && rn != 0;
					end
					default: begin
						// cross-multiply, then add in sign-magnitude form
						p = an * od;
						q = on * ad;
						rd = ad * od;
						ovf = p > MAG_MAX || q > MAG_MAX || rd > MAG_MAX;
						sb = on_neg != (op == OP_SUB);
						if (an_neg == sb) begin
							rn = p + q;
							rneg = an_neg;
						end else if (p >= q) begin
							rn = p - q;
							rneg = an_neg;
						end else begin
							rn = q - p;
							rneg = sb;
						end
						if (rn > MAG_MAX)
							ovf = 1'b1;
						rneg = rneg && rn != 0;
					end
				endcase
				if (ovf)
					frac_err = ERR_OVERFLOW;
				else
					store_frac(rneg, rn, rd);
			end
		end
		emits = lst;
		res = '0;
		if (lst) begin
			if (frac_err != ERR_NONE) begin
				res.num = '0;
				res.den = RES_DEN_W'(1);
				res.err = frac_err;
			end else begin
				an_neg = frac_num < 0;
				an = an_neg ? longint'(-frac_num) : longint'(frac_num);
				// Euclid on denominator and magnitude
				a = frac_den;
				b = an;
				while (b != 0) begin
					t = a % b;
					a = b;
					b = t;
				end
				if (a == 0)
					a = 1;
				store_frac(an_neg && an / a != 0, an / a, frac_den / a);
				res.num = frac_num[RES_NUM_W-1:0];
				res.den = frac_den[RES_DEN_W-1:0];
				res.err = ERR_NONE;
			end
		end
	endtask

	// Send one item word, then predict its result once it is accepted
	task automatic send_word(input op_t op, input logic signed [OPERAND_WIDTH-1:0] num,
			input logic [OPD_W-1:0] den, input bit fst, input bit lst);
		int gap;
		bit emits;
		frac_result_t res;
		gap = no_idle ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		operation <= op;
		numerator <= num;
		denominator <= den;
		first <= fst;
		last <= lst;
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (!item_ready);
		words_sent++;
		if (fst || frac_err == ERR_NONE)
			live_words++;
		fold_word(op, num, den, fst, lst, emits, res);
		if (emits)
			reduced_q.push_back(res);
		@(negedge clk);
	endtask

	function automatic logic signed [OPERAND_WIDTH-1:0] pick_num();
		int v;
		if ($urandom_range(0, 3) == 0)
			return OPERAND_WIDTH'($urandom);
		v = $urandom_range(0, 40);
		v = v - 20;
		return v[OPERAND_WIDTH-1:0];
	endfunction

	function automatic logic [OPD_W-1:0] pick_den();
		int r;
		r = $urandom_range(0, 39);
		if (r == 0)
			return '0;
		if (r < 10)
			return OPD_W'($urandom);
		return OPD_W'($urandom_range(1, 20));
	endfunction

	// Load-and-reduce words, mostly at the field extremes
	task automatic test_load_emit;
		send_word(OP_MUL, 16'sd32767, 15'd1, 1'b1, 1'b1);
		send_word(OP_DIV, -16'sd32768, 15'd32767, 1'b1, 1'b1);
		send_word(OP_ADD, 16'sd0, 15'd5, 1'b1, 1'b1);
		send_word(OP_SUB, -16'sd1, 15'd32767, 1'b1, 1'b1);
		send_word(OP_MUL, 16'sd12, 15'd18, 1'b1, 1'b1);
	endtask

	// One run through every operation, then continue from the reduced value
	task automatic test_operations;
		send_word(OP_MUL, 16'sd3, 15'd4, 1'b1, 1'b0);
		send_word(OP_MUL, -16'sd5, 15'd6, 1'b0, 1'b0);
		send_word(OP_ADD, 16'sd7, 15'd10, 1'b0, 1'b0);
		send_word(OP_SUB, 16'sd1, 15'd3, 1'b0, 1'b0);
		send_word(OP_DIV, -16'sd2, 15'd9, 1'b0, 1'b1);
		send_word(OP_ADD, 16'sd1, 15'd2, 1'b0, 1'b1);
	endtask

	// Zero operand denominator and divide by a zero fraction; error sticks
	task automatic test_zero_divisor;
		send_word(OP_MUL, 16'sd4, 15'd0, 1'b1, 1'b1);
		send_word(OP_MUL, 16'sd1, 15'd2, 1'b1, 1'b0);
		send_word(OP_DIV, 16'sd0, 15'd7, 1'b0, 1'b1);
		send_word(OP_MUL, 16'sd1, 15'd2, 1'b1, 1'b0);
		send_word(OP_ADD, 16'sd3, 15'd0, 1'b0, 1'b0);
		send_word(OP_MUL, 16'sd3, 15'd4, 1'b0, 1'b1);
	endtask

	// Push the magnitude past the accumulator range, then recover with a load
	task automatic test_overflow;
		send_word(OP_MUL, -16'sd32768, 15'd32767, 1'b1, 1'b0);
		send_word(OP_MUL, -16'sd32768, 15'd32767, 1'b0, 1'b0);
		send_word(OP_MUL, 16'sd2, 15'd1, 1'b0, 1'b0);
		send_word(OP_ADD, 16'sd1, 15'd1, 1'b0, 1'b1);
		send_word(OP_SUB, 16'sd9, 15'd6, 1'b1, 1'b1);
	endtask

	// Mostly well-formed runs with random content, some noise and continuations
	task automatic test_random_runs;
		int mode;
		int len;
		while (words_sent < RANDOM_WORDS) begin
			if ($urandom_range(0, 3) == 0)
				no_idle = ~no_idle;
			mode = $urandom_range(0, 7);
			if (mode == 0) begin
				send_word(op_t'($urandom_range(0, 3)), pick_num(), pick_den(),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end else begin
				len = $urandom_range(0, 5);
				if (mode == 1 && len == 0)
					len = 1;
				if (mode != 1)
					send_word(op_t'($urandom_range(0, 3)), pick_num(), pick_den(),
						1'b1, len == 0);
				for (int i = 1; i <= len; i++)
					send_word(op_t'($urandom_range(0, 3)), pick_num(), pick_den(),
						1'b0, i == len);
			end
		end
		no_idle = 1'b0;
	endtask

	// Take result words with a random stall before each
	initial begin : result_sink
		int stall;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 7);
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_ready <= 1'b1;
			do
				@(posedge clk);
			while (!result_valid);
			@(negedge clk);
		end
	end

	// Compare each accepted result word with the oldest reduced fraction
	always @(posedge clk) begin : result_check
		frac_result_t want;
		if (arst_n && result_valid && result_ready) begin
			results_seen++;
			if (error_code != ERR_NONE)
				error_results++;
			if (reduced_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: %0d/%0d err %0d",
						result_numerator, result_denominator, error_code);
			end else begin
				want = reduced_q.pop_front();
				if (result_numerator !== want.num || result_denominator !== want.den ||
						error_code !== want.err) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: expected %0d/%0d err %0d, got %0d/%0d err %0d",
							results_seen, want.num, want.den, want.err,
							result_numerator, result_denominator, error_code);
				end
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, reduced_q.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_load_emit;
		test_operations;
		test_zero_divisor;
		test_overflow;
		test_random_runs;
		item_valid <= 1'b0;
		// drain outstanding results, then watch for strays
		while (reduced_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d item words sent (%0d not ignored), %0d reduced fractions checked",
			words_sent, live_words, results_seen);
		$display("%0d results carried an error code, %0d mismatches", error_results,
			mismatches);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

### sim.f
hw/rtl/fracc_pkg.sv
hw/rtl/fracc_div.sv
hw/rtl/fracc_dp.sv
hw/rtl/fracc_ctrl.sv
hw/rtl/fraction_accumulator_reduce.sv
bench/testbench.sv
